>>> rtl/tcpt_pkg.sv
package tcpt_pkg;

	// time base kept modulo 2^TIME_BITS
	localparam int TIME_BITS = 32;
	localparam int NOW_W     = 32;

	localparam int PCT_W     = 7;
	localparam int TRAVEL_W  = 16;
	// elapsed below budget (<= 2 * 65535) fits here
	localparam int ELAPSED_W = TRAVEL_W + 1;
	localparam int PROD_W    = PCT_W + ELAPSED_W;
	localparam int CD_W      = 8;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [PCT_W-1:0]     pct_t;
	typedef logic [TRAVEL_W-1:0]  travel_t;
	typedef logic [ELAPSED_W-1:0] elap_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [CD_W-1:0]      cd_t;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_STOP = 2'd1;
	localparam logic [1:0] OP_MOVE = 2'd2;

	localparam logic [2:0] TGT_CLOSED = 3'd0;
	localparam logic [2:0] TGT_OPEN   = 3'd1;

	localparam logic [1:0] DIR_STOP  = 2'd0;
	localparam logic [1:0] DIR_OPEN  = 2'd1;
	localparam logic [1:0] DIR_CLOSE = 2'd2;

	localparam logic [1:0] POS_CLOSED  = 2'd0;
	localparam logic [1:0] POS_OPEN    = 2'd1;
	localparam logic [1:0] POS_PARTIAL = 2'd2;

	localparam logic STATUS_OK         = 1'b0;
	localparam logic STATUS_CONSTRAINT = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_FULL_TRAVEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OVERSHOOT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RELAY_POL   = 2'd2;

	localparam travel_t FULL_TRAVEL_RST = 16'd15000;
	localparam travel_t OVERSHOOT_RST   = 16'd1500;
	localparam travel_t MS_PER_S        = 16'd1000;
	localparam pct_t    PCT_FULL        = 7'd100;

	function automatic logic [1:0] coarse_pos(pct_t pct);
		logic [1:0] r;
		if (pct == '0) r = POS_CLOSED;
		else if (pct >= PCT_FULL) r = POS_OPEN;
		else r = POS_PARTIAL;
		return r;
	endfunction

endpackage

>>> rtl/timed_closure_position_tracker_unit.sv
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | opcode, now_ms, target_position, target_present
// out     | out | out_valid/out_stall| command_status .. movement_completed (11 fields)
// cfg     | in  | APB psel/penable   | full_travel_ms, overshoot_ms, relay_active_low
//
// One item at a time. Stop, idle tick, rejected or empty move: decided in ST_CHECK, loaded from ST_OUT.
// Accepted move: budget / 1000 on the serial divider (24 steps) in ST_CDIV.
// Tick while moving: the 7-step serial multiply followed by the
// 24-step serial divide by travel time; the countdown divide runs alongside.
// Reset: motor stopped, estimate closed, secure published as 1; config at defaults.
// The next item is taken while a result waits in the output register; a stalled
// result holds the final step until out_stall drops.
module timed_closure_position_tracker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [tcpt_pkg::NOW_W-1:0]    now_ms,
	input  logic [2:0]                    target_position,
	input  logic                          target_present,
	// result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          command_status,
	output logic                          relay_open_level,
	output logic                          relay_close_level,
	output logic                          moving,
	output logic [1:0]                    position_state,
	output logic                          secure,
	output logic                          state_report,
	output logic                          secure_changed,
	output logic [tcpt_pkg::CD_W-1:0]     countdown_s,
	output logic                          countdown_update,
	output logic                          movement_completed,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcpt_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcpt_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcpt_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import tcpt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_CDIV  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	// estimate from start point and traveled percent d
	function automatic pct_t next_est(pct_t start, logic to_open, prod_t d);
		logic [PCT_W:0] sum;
		pct_t           r;
		sum = {1'b0, start} + {1'b0, d[PCT_W-1:0]};
		if (to_open) begin
			if ((|d[PROD_W-1:PCT_W]) || (sum > {1'b0, PCT_FULL})) r = PCT_FULL;
			else r = sum[PCT_W-1:0];
		end else begin
			if (d >= PROD_W'(start)) r = '0;
			else r = start - d[PCT_W-1:0];
		end
		return r;
	endfunction

	// config registers
	travel_t full_travel_q;
	travel_t overshoot_q;
	logic    relay_low_q;

	// tracker state
	logic       active_q;
	time_t      start_time_q;
	pct_t       start_pct_q;
	logic       target_open_q;
	pct_t       cur_pct_q;
	logic       last_secure_q;
	logic [1:0] dir_q;

	// item being worked
	logic [2:0] state_q;
	logic [1:0] op_q;
	time_t      now_q;
	logic [2:0] tpos_q;
	logic       tpres_q;
	time_t      elapsed_q;

	// result flags
	logic status_q;
	logic report_q;
	cd_t  cd_q;
	logic cd_upd_q;
	logic completed_q;

	// output register
	logic       ovalid_q;
	logic       o_status_q;
	logic       o_ropen_q;
	logic       o_rclose_q;
	logic       o_moving_q;
	logic [1:0] o_pos_q;
	logic       o_secure_q;
	logic       o_report_q;
	logic       o_secchg_q;
	cd_t        o_cd_q;
	logic       o_cdupd_q;
	logic       o_done_q;

	logic       cfg_wr;
	logic       in_acc;
	travel_t    travel;
	elap_t      budget;
	elap_t      elapsed_lo;
	pct_t       tgt_pct;
	pct_t       mag;
	logic       expired;
	logic       move_ok;
	logic       mul_start;
	logic       cdiv_start;
	logic       qdiv_start;
	prod_t      cd_dividend;
	prod_t      product;
	logic       mul_done;
	prod_t      cd_quo;
	logic       cdiv_done;
	prod_t      q_quo;
	logic       qdiv_done;
	pct_t       est;
	logic       out_free;
	logic       sec_now;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_travel_q <= FULL_TRAVEL_RST;
			overshoot_q   <= OVERSHOOT_RST;
			relay_low_q   <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1:2])
				REG_FULL_TRAVEL: full_travel_q <= pwdata[TRAVEL_W-1:0];
				REG_OVERSHOOT:   overshoot_q   <= pwdata[TRAVEL_W-1:0];
				REG_RELAY_POL:   relay_low_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1:2])
			REG_FULL_TRAVEL: prdata = PDATA_W'(full_travel_q);
			REG_OVERSHOOT:   prdata = PDATA_W'(overshoot_q);
			REG_RELAY_POL:   prdata = PDATA_W'(relay_low_q);
			default:         prdata = '0;
		endcase
	end

	// zero travel counts as 1 ms, so the divisor never reaches zero
	assign travel     = (full_travel_q == '0) ? TRAVEL_W'(1) : full_travel_q;
	assign budget     = {1'b0, travel} + {1'b0, overshoot_q};
	assign elapsed_lo = elapsed_q[ELAPSED_W-1:0];
	assign expired    = (elapsed_q >= TIME_BITS'(budget));
	assign tgt_pct    = target_open_q ? PCT_FULL : '0;
	assign mag        = (tgt_pct > start_pct_q) ? (tgt_pct - start_pct_q)
	                                            : (start_pct_q - tgt_pct);
	assign move_ok    = tpres_q && (tpos_q <= TGT_OPEN);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;

	assign mul_start  = (state_q == ST_CHECK) && (op_q == OP_TICK) && active_q && !expired;
	assign cdiv_start = mul_start ||
	                    ((state_q == ST_CHECK) && (op_q == OP_MOVE) && move_ok);
	assign qdiv_start = (state_q == ST_MUL) && mul_done;
	// move: full budget; tick: budget left
	assign cd_dividend = (op_q == OP_MOVE) ? PROD_W'(budget) : PROD_W'(budget - elapsed_lo);

	tcpt_smul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mag),
		.b       (elapsed_lo),
		.product (product),
		.done    (mul_done)
	);

	tcpt_sdiv u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (qdiv_start),
		.dividend (product),
		.divisor  (travel),
		.quotient (q_quo),
		.done     (qdiv_done)
	);

	tcpt_sdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cdiv_start),
		.dividend (cd_dividend),
		.divisor  (MS_PER_S),
		.quotient (cd_quo),
		.done     (cdiv_done)
	);

	assign est     = next_est(start_pct_q, target_open_q, q_quo);
	assign sec_now = (cur_pct_q == '0);

	// item capture and sequencer
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= opcode;
			now_q     <= TIME_BITS'(now_ms);
			tpos_q    <= target_position;
			tpres_q   <= target_present;
			elapsed_q <= TIME_BITS'(now_ms) - start_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_q      <= 1'b0;
			start_time_q  <= '0;
			start_pct_q   <= '0;
			target_open_q <= 1'b0;
			cur_pct_q     <= '0;
			last_secure_q <= 1'b1;
			dir_q         <= DIR_STOP;
			status_q      <= STATUS_OK;
			report_q      <= 1'b0;
			cd_q          <= '0;
			cd_upd_q      <= 1'b0;
			completed_q   <= 1'b0;
			ovalid_q      <= 1'b0;
		end else begin
			// load on the final step, drop once taken
			if ((state_q == ST_OUT) && out_free) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q     <= ST_CHECK;
						status_q    <= STATUS_OK;
						report_q    <= 1'b0;
						cd_q        <= '0;
						cd_upd_q    <= 1'b0;
						completed_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					state_q <= ST_OUT;
					unique case (op_q)
						OP_TICK: begin
							if (active_q) begin
								if (expired) begin
									// full travel plus overshoot done: snap to end
									cur_pct_q   <= tgt_pct;
									report_q    <= 1'b1;
									active_q    <= 1'b0;
									dir_q       <= DIR_STOP;
									cd_upd_q    <= 1'b1;
									completed_q <= 1'b1;
								end else begin
									state_q <= ST_MUL;
								end
							end
						end
						OP_STOP: begin
							completed_q <= active_q;
							active_q    <= 1'b0;
							dir_q       <= DIR_STOP;
							cd_upd_q    <= 1'b1;
						end
						OP_MOVE: begin
							if (tpres_q) begin
								if (move_ok) begin
									start_pct_q   <= cur_pct_q;
									target_open_q <= (tpos_q == TGT_OPEN);
									start_time_q  <= now_q;
									active_q      <= 1'b1;
									dir_q         <= (tpos_q == TGT_OPEN) ? DIR_OPEN : DIR_CLOSE;
									state_q       <= ST_CDIV;
								end else begin
									status_q <= STATUS_CONSTRAINT;
								end
							end
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					if (mul_done) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (qdiv_done) begin
						// countdown divide started earlier and is already finished
						if (coarse_pos(est) != coarse_pos(cur_pct_q)) report_q <= 1'b1;
						cur_pct_q <= est;
						cd_q      <= cd_quo[CD_W-1:0];
						cd_upd_q  <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_CDIV: begin
					if (cdiv_done) begin
						cd_q     <= cd_quo[CD_W-1:0];
						cd_upd_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q  <= ST_IDLE;
						if (report_q) last_secure_q <= sec_now;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload, loaded with the final step
	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			o_status_q <= status_q;
			o_ropen_q  <= (dir_q == DIR_OPEN) ^ relay_low_q;
			o_rclose_q <= (dir_q == DIR_CLOSE) ^ relay_low_q;
			o_moving_q <= active_q;
			o_pos_q    <= coarse_pos(cur_pct_q);
			o_secure_q <= sec_now;
			o_report_q <= report_q;
			o_secchg_q <= report_q && (sec_now != last_secure_q);
			o_cd_q     <= cd_q;
			o_cdupd_q  <= cd_upd_q;
			o_done_q   <= completed_q;
		end
	end

	assign out_valid          = ovalid_q;
	assign command_status     = o_status_q;
	assign relay_open_level   = o_ropen_q;
	assign relay_close_level  = o_rclose_q;
	assign moving             = o_moving_q;
	assign position_state     = o_pos_q;
	assign secure             = o_secure_q;
	assign state_report       = o_report_q;
	assign secure_changed     = o_secchg_q;
	assign countdown_s        = o_cd_q;
	assign countdown_update   = o_cdupd_q;
	assign movement_completed = o_done_q;

endmodule

>>> rtl/tcpt_smul.sv
// shift-add multiplier, one multiplier bit per cycle
module tcpt_smul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tcpt_pkg::pct_t  a,
	input  tcpt_pkg::elap_t b,
	output tcpt_pkg::prod_t product,
	output logic            done
);
	import tcpt_pkg::*;

	localparam int CNT_W = $clog2(PCT_W);

	pct_t             a_q;
	prod_t            b_q;
	prod_t            acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PCT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= PROD_W'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) acc_q <= acc_q + b_q;
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

>>> rtl/tcpt_sdiv.sv
// restoring divider, one quotient bit per cycle; quotient holds until next start
module tcpt_sdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tcpt_pkg::prod_t   dividend,
	input  tcpt_pkg::travel_t divisor,
	output tcpt_pkg::prod_t   quotient,
	output logic              done
);
	import tcpt_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	prod_t              dvd_q;
	prod_t              quo_q;
	logic [TRAVEL_W:0]  rem_q;
	travel_t            dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [TRAVEL_W:0]  trial;
	logic               qbit;

	always_comb begin
		trial = {rem_q[TRAVEL_W-1:0], dvd_q[PROD_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[PROD_W-2:0], qbit};
			rem_q <= qbit ? (trial - {1'b0, dsr_q}) : trial;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> rtl/tcpt_checker.sv
module tcpt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         moving,
	input logic [1:0]                   position_state,
	input logic                         secure,
	input logic [tcpt_pkg::CD_W-1:0]    countdown_s,
	input logic                         countdown_update,
	input logic                         movement_completed
);
	import tcpt_pkg::*;

	// stalled item is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(countdown_s) && $stable(moving))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted item while busy");

	a_cd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !countdown_update |-> countdown_s == '0)
		else $error("countdown without update");

	a_secure_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> secure == (position_state == POS_CLOSED))
		else $error("secure disagrees with position");

	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && movement_completed |-> !moving)
		else $error("completed while moving");

endmodule

bind timed_closure_position_tracker_unit tcpt_checker u_tcpt_checker (.*);

>>> tb/tb_timed_closure_position_tracker_unit.sv
// Self-checking bench for the sensorless closure position tracker.
// A local model of the tracker predicts one report per accepted command;
// reports are compared field by field in order of arrival.
// Flow: reset, directed table at default calibration, random traffic, then
// several calibration phases (shortest, longest, zero travel, random).
module tb_timed_closure_position_tracker_unit;
	import tcpt_pkg::*;

	// opcode 3 is not assigned; the block must report success and do nothing
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// receiver hold-off that backs the block up into its input
	localparam int HOLD_CYCLES = 300;
	// idle percentage on each side
	localparam int IDLE_PCT = 36;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [NOW_W-1:0] now_ms;
		logic [2:0]       target_position;
		logic             target_present;
	} cmd_t;

	typedef struct packed {
		logic       command_status;
		logic       relay_open_level;
		logic       relay_close_level;
		logic       moving;
		logic [1:0] position_state;
		logic       secure;
		logic       state_report;
		logic       secure_changed;
		cd_t        countdown_s;
		logic       countdown_update;
		logic       movement_completed;
	} report_t;

	// one row of the directed table; typed rows carry a hand-written report
	typedef struct {
		cmd_t    cmd;
		bit      typed;
		report_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          opcode = OP_TICK;
	logic [NOW_W-1:0]    now_ms = '0;
	logic [2:0]          target_position = TGT_CLOSED;
	logic                target_present = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                command_status;
	logic                relay_open_level;
	logic                relay_close_level;
	logic                moving;
	logic [1:0]          position_state;
	logic                secure;
	logic                state_report;
	logic                secure_changed;
	logic [CD_W-1:0]     countdown_s;
	logic                countdown_update;
	logic                movement_completed;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	timed_closure_position_tracker_unit u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// calibration as the block should hold it
	travel_t cfg_travel = FULL_TRAVEL_RST;
	travel_t cfg_overshoot = OVERSHOOT_RST;
	logic    cfg_active_low = 1'b1;

	// tracker state, reset values
	logic    trk_active = 1'b0;
	time_t   trk_start = '0;
	pct_t    trk_from = '0;
	logic    trk_to_open = 1'b0;
	pct_t    trk_pct = '0;
	logic    trk_last_secure = 1'b1;
	logic [1:0] trk_dir = DIR_STOP;

	report_t    due_reports[$];
	stim_row_t  plan[$];
	int         n_bad = 0;
	bit         calm = 1'b0;        // no idling on either side
	bit         hold_start = 1'b0;  // request for the long receiver hold-off
	logic [31:0] clock_ms = '0;     // wall time fed to the block

	function automatic logic [1:0] pos_of(input pct_t p);
		return (p == '0) ? POS_CLOSED : (p < PCT_FULL) ? POS_PARTIAL : POS_OPEN;
	endfunction

	function automatic logic [17:0] run_budget();
		logic [16:0] span;
		span = (cfg_travel == '0) ? 17'd1 : {1'b0, cfg_travel};
		return {1'b0, span} + {2'b0, cfg_overshoot};
	endfunction

	// Advances the tracker by one command and returns the report it owes.
	function automatic report_t advance_tracker(input cmd_t c);
		report_t     r;
		logic [16:0] span;
		logic [17:0] budget;
		logic [31:0] elapsed;
		pct_t        goal, gap, est;
		logic [47:0] moved, reach;
		r = '0;
		span = (cfg_travel == '0) ? 17'd1 : {1'b0, cfg_travel};
		budget = run_budget();
		case (c.opcode)
		OP_TICK: begin
			if (trk_active) begin
				elapsed = c.now_ms - trk_start;  // wraps with the time base
				goal = trk_to_open ? PCT_FULL : '0;
				if (elapsed >= {14'b0, budget}) begin
					// travel plus overshoot spent: snap to the end stop
					trk_pct = goal;
					trk_active = 1'b0;
					trk_dir = DIR_STOP;
					r.state_report = 1'b1;
					r.countdown_update = 1'b1;
					r.movement_completed = 1'b1;
				end else begin
					gap = (goal > trk_from) ? goal - trk_from : trk_from - goal;
					moved = ({41'b0, gap} * {16'b0, elapsed}) / {31'b0, span};
					if (goal > trk_from) begin
						reach = {41'b0, trk_from} + moved;
						est = (reach > 48'd100) ? PCT_FULL : reach[6:0];
					end else begin
						est = (moved >= {41'b0, trk_from}) ? '0 : trk_from - moved[6:0];
					end
					// publish only on a coarse change
					if (pos_of(est) != pos_of(trk_pct))
						r.state_report = 1'b1;
					trk_pct = est;
					r.countdown_s = cd_t'((budget - elapsed[17:0]) / MS_PER_S);
					r.countdown_update = 1'b1;
				end
			end
		end
		OP_STOP: begin
			r.movement_completed = trk_active;
			trk_active = 1'b0;
			trk_dir = DIR_STOP;
			r.countdown_update = 1'b1;
		end
		OP_MOVE: begin
			if (c.target_present) begin
				if (c.target_position == TGT_CLOSED || c.target_position == TGT_OPEN) begin
					// restart from the estimate, full budget, even if already there
					trk_from = trk_pct;
					trk_to_open = (c.target_position == TGT_OPEN);
					trk_start = c.now_ms;
					trk_active = 1'b1;
					trk_dir = trk_to_open ? DIR_OPEN : DIR_CLOSE;
					r.countdown_s = cd_t'(budget / MS_PER_S);
					r.countdown_update = 1'b1;
				end else begin
					r.command_status = STATUS_CONSTRAINT;
				end
			end
		end
		default: ;
		endcase
		r.secure = (trk_pct == '0);
		if (r.state_report && r.secure != trk_last_secure) begin
			r.secure_changed = 1'b1;
			trk_last_secure = r.secure;
		end
		r.relay_open_level = (trk_dir == DIR_OPEN) ^ cfg_active_low;
		r.relay_close_level = (trk_dir == DIR_CLOSE) ^ cfg_active_low;
		r.moving = trk_active;
		r.position_state = pos_of(trk_pct);
		return r;
	endfunction

	// Offers one command, waits for acceptance, then books the report.
	task automatic offer(input cmd_t c, input bit typed, input report_t want);
		report_t pred;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode <= c.opcode;
		now_ms <= c.now_ms;
		target_position <= c.target_position;
		target_present <= c.target_present;
		do @(posedge clk); while (in_stall);
		pred = advance_tracker(c);
		due_reports.push_back(typed ? want : pred);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_FULL_TRAVEL: cfg_travel = val[TRAVEL_W-1:0];
		REG_OVERSHOOT:   cfg_overshoot = val[TRAVEL_W-1:0];
		REG_RELAY_POL:   cfg_active_low = val[0];
		default: ;
		endcase
	endtask

	// New calibration, only once the block has drained.
	task automatic retune(input travel_t tr, input travel_t os, input logic pol);
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		reg_write(REG_FULL_TRAVEL, {16'b0, tr});
		reg_write(REG_OVERSHOOT, {16'b0, os});
		reg_write(REG_RELAY_POL, {31'b0, pol});
	endtask

	// Mostly real movements (move, a run of ticks, maybe a stop), some noise.
	task automatic run_random(input int n);
		int          sent;
		int          k;
		logic [31:0] t0, el;
		logic [17:0] bgt;
		cmd_t        c;
		sent = 0;
		while (sent < n) begin
			bgt = run_budget();
			if ($urandom_range(0, 9) < 7) begin
				// jump anywhere, wrap-around included
				if ($urandom_range(0, 7) == 0)
					clock_ms = $urandom;
				t0 = clock_ms;
				el = '0;
				c = '{OP_MOVE, t0, 3'($urandom_range(0, 1)), 1'b1};
				offer(c, 1'b0, '0);
				sent++;
				k = $urandom_range(1, 8);
				repeat (k) begin
					case ($urandom_range(0, 7))
					0: el = {14'b0, bgt} - 32'd1;   // last ms before the end stop
					1: el = {14'b0, bgt};           // exactly at the end stop
					default: el = el + $urandom_range(0, bgt / 3 + 1);
					endcase
					// target fields are don't-care on a tick
					c = '{OP_TICK, t0 + el, 3'($urandom), 1'($urandom)};
					offer(c, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 3) == 0) begin
					c = '{OP_STOP, t0 + el + 32'd1, 3'($urandom), 1'($urandom)};
					offer(c, 1'b0, '0);
					sent++;
				end
				clock_ms = t0 + el + $urandom_range(1, 2000);
			end else begin
				c = '{2'($urandom), $urandom, 3'($urandom), 1'($urandom)};
				offer(c, 1'b0, '0);
				sent++;
			end
		end
	endtask

	function automatic void add_row(input logic [1:0] op, input logic [31:0] t,
			input logic [2:0] tpos, input logic pres, input bit typed, input report_t want);
		stim_row_t row;
		row.cmd = '{op, t, tpos, pres};
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	// Directed table at default calibration (15 s travel, 1.5 s overshoot,
	// active-low relays). Only the obvious reports are typed in.
	function automatic void load_plan();
		report_t idle_r, stop_r, err_r, open_r;
		idle_r = '{STATUS_OK, 1'b1, 1'b1, 1'b0, POS_CLOSED, 1'b1, 1'b0, 1'b0,
			8'd0, 1'b0, 1'b0};
		stop_r = idle_r;
		stop_r.countdown_update = 1'b1;
		err_r = idle_r;
		err_r.command_status = STATUS_CONSTRAINT;
		// opening: open relay pin pulled low, countdown 16500 / 1000
		open_r = '{STATUS_OK, 1'b0, 1'b1, 1'b1, POS_CLOSED, 1'b1, 1'b0, 1'b0,
			8'd16, 1'b1, 1'b0};
		// idle ticks, time extremes: nothing published
		add_row(OP_TICK,   32'h0000_0000, TGT_CLOSED, 1'b0, 1'b1, idle_r);
		add_row(OP_TICK,   32'hFFFF_FFFF, 3'd7,       1'b1, 1'b1, idle_r);
		// stop while idle: countdown only, no completion
		add_row(OP_STOP,   32'd0,         TGT_CLOSED, 1'b0, 1'b1, stop_r);
		add_row(OP_UNUSED, 32'd0,         TGT_OPEN,   1'b1, 1'b1, idle_r);
		// move with no target is accepted and ignored
		add_row(OP_MOVE,   32'd0,         TGT_OPEN,   1'b0, 1'b1, idle_r);
		// unsupported targets
		add_row(OP_MOVE,   32'd0,         3'd7,       1'b1, 1'b1, err_r);
		add_row(OP_MOVE,   32'd0,         3'd2,       1'b1, 1'b1, err_r);
		// full open run: half way, full, last ms, end stop
		add_row(OP_MOVE,   32'd1000,      TGT_OPEN,   1'b1, 1'b1, open_r);
		add_row(OP_TICK,   32'd8500,      TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_TICK,   32'd16000,     TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_TICK,   32'd17499,     TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_TICK,   32'd17500,     TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_TICK,   32'd17500,     TGT_CLOSED, 1'b0, 1'b0, '0);
		// move to where it already is, then stop mid-run
		add_row(OP_MOVE,   32'd20000,     TGT_OPEN,   1'b1, 1'b0, '0);
		add_row(OP_STOP,   32'd21000,     TGT_CLOSED, 1'b0, 1'b0, '0);
		// close across the 32-bit wrap, then reverse while moving
		add_row(OP_MOVE,   32'hFFFF_F000, TGT_CLOSED, 1'b1, 1'b0, '0);
		add_row(OP_TICK,   32'h0000_0BB8, TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_MOVE,   32'h0000_1000, TGT_OPEN,   1'b1, 1'b0, '0);
		add_row(OP_TICK,   32'h0000_2000, TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_MOVE,   32'h0000_3000, TGT_CLOSED, 1'b1, 1'b0, '0);
		add_row(OP_TICK,   32'h0000_3000 + 32'd16499, TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_TICK,   32'h0000_3000 + 32'd16500, TGT_CLOSED, 1'b0, 1'b0, '0);
		add_row(OP_MOVE,   32'd0,         3'd3,       1'b0, 1'b0, '0);
		add_row(OP_STOP,   32'd0,         TGT_CLOSED, 1'b0, 1'b0, '0);
	endfunction

	task automatic chk(input string fld, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fld, want, got);
			n_bad++;
		end
	endtask

	// Report side: checks at each taken report, then picks the next stall.
	initial begin
		int      hold_left;
		report_t w;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					$error("report arrived with nothing outstanding");
					n_bad++;
				end else begin
					w = due_reports.pop_front();
					chk("command_status", w.command_status, command_status);
					chk("relay_open_level", w.relay_open_level, relay_open_level);
					chk("relay_close_level", w.relay_close_level, relay_close_level);
					chk("moving", w.moving, moving);
					chk("position_state", w.position_state, position_state);
					chk("secure", w.secure, secure);
					chk("state_report", w.state_report, state_report);
					chk("secure_changed", w.secure_changed, secure_changed);
					chk("countdown_s", w.countdown_s, countdown_s);
					chk("countdown_update", w.countdown_update, countdown_update);
					chk("movement_completed", w.movement_completed, movement_completed);
				end
			end
			if (hold_start) begin
				hold_left = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_plan();
		foreach (plan[i])
			offer(plan[i].cmd, plan[i].typed, plan[i].want);
		run_random(150);
		// shortest travel, no overshoot, active-high relays
		retune(16'd1, 16'd0, 1'b0);
		run_random(90);
		// longest travel and overshoot: countdown tops out at 131 s
		retune(16'hFFFF, 16'hFFFF, 1'b1);
		run_random(90);
		// zero travel behaves as 1 ms
		retune(16'd0, 16'd700, 1'b0);
		run_random(80);
		retune(travel_t'($urandom_range(1000, 20000)), travel_t'($urandom_range(0, 3000)),
			1'($urandom));
		// a stretch with no idling, then back-pressure from the report side
		calm = 1'b1;
		run_random(60);
		calm = 1'b0;
		hold_start = 1'b1;
		run_random(110);
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (n_bad == 0)
			$display("tb_timed_closure_position_tracker_unit: done, clean");
		else
			$display("tb_timed_closure_position_tracker_unit: done, errors");
		$finish;
	end

	// hang guard: well above the slowest expected run
	initial begin
		#4000000;
		$display("tb_timed_closure_position_tracker_unit: done, errors");
		$finish;
	end

endmodule
